// ===== design/lzwc_pkg.sv =====
// Shared types, constants and defaults of the LZW compressor.
package lzwc_pkg;

   localparam int START_WIDTH_DEF  = 9;
   localparam int MAX_WIDTH_DEF    = 12;
   localparam int DICT_ENTRIES_DEF = 4096;
   localparam int HASH_SLOTS_DEF   = 8192;

   localparam int CODE_CLEAR = 256;
   localparam int CODE_STOP  = 257;
   localparam int CODE_FIRST = 258;

   localparam int WORD_BITS  = 32;
   localparam int PACK_VAL_W = 16;
   localparam int PACK_LEN_W = 5;

   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_EMIT_CUR,
      ST_EMIT_CLR,
      ST_EMIT_STOP,
      ST_FLUSH
   } lzwc_state_type;

   typedef struct packed {
      logic                  emit;
      logic                  flush;
      logic [PACK_VAL_W-1:0] value;
      logic [PACK_LEN_W-1:0] nbits;
   } lzwc_pack_cmd_type;

   typedef struct packed {
      logic                 word_done;
      logic [WORD_BITS-1:0] word;
      logic [2:0]           count;
      logic                 empty_after;
   } lzwc_pack_out_type;

endpackage

// ===== design/lzwc_if.sv =====
// Handshake interfaces of the input byte channel and the packed word channel.
interface lzwc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface lzwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_word;
   logic [2:0]  byte_count;
   logic        stream_end;

   modport source (output valid, output packed_word, output byte_count, output stream_end,
                   input ready);
   modport sink (input valid, input packed_word, input byte_count, input stream_end,
                 output ready);
endinterface

// ===== design/lzwc_dict_mem.sv =====
// Single-port-write, registered-read memory that holds the dictionary hash slots.
module lzwc_dict_mem #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 35
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/lzwc_packer.sv =====
// Bit packer that places codes MSB-first into 32-bit words.
module lzwc_packer import lzwc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lzwc_pack_cmd_type cmd,
   output lzwc_pack_out_type res
);

   logic [WORD_BITS-1:0] buf_ff, buf_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [5:0]           room, used, rem;
   logic [WORD_BITS-1:0] val32, lowpart;
   logic [5:0]           flush_bytes;

   always_comb begin
      val32       = {{(WORD_BITS - PACK_VAL_W){1'b0}}, cmd.value};
      room        = 6'd32 - {1'b0, cnt_ff};
      used        = {1'b0, cnt_ff} + {1'b0, cmd.nbits};
      rem         = used - 6'd32;
      lowpart     = val32 & ((32'd1 << room) - 32'd1);
      flush_bytes = ({1'b0, cnt_ff} + 6'd7) >> 3;
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      res.word_done   = 1'b0;
      res.word        = buf_ff;
      res.count       = 3'd4;
      res.empty_after = (cnt_ff == 5'd0);
      if (cmd.flush) begin
         res.word_done   = 1'b1;
         res.count       = flush_bytes[2:0];
         res.empty_after = 1'b1;
         buf_in          = '0;
         cnt_in          = '0;
      end else if (cmd.emit) begin
         if (used < 6'd32) begin
            buf_in          = buf_ff | (val32 << (6'd32 - used));
            cnt_in          = used[4:0];
            res.empty_after = 1'b0;
         end else begin
            // The low part closes this word, the high part opens the next one.
            res.word_done   = 1'b1;
            res.word        = buf_ff | lowpart;
            buf_in          = (rem == 6'd0) ? '0 : ((val32 >> room) << (6'd32 - rem));
            cnt_in          = rem[4:0];
            res.empty_after = (rem == 6'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/lzw_compressor_packed_unit.sv =====
// Top level of the LZW compressor with variable code width and 32-bit word packing.
//
//   channel | direction | payload                                  | handshake
//   req     | in        | action, data_byte                        | valid/ready
//   rsp     | out       | packed_word, byte_count, stream_end      | valid/ready
//
// A byte whose string is found passes through accept, memory read and compare;
// a miss adds an emit step, and each hash collision adds another probe and
// compare for another read of the dictionary memory. The single read port of
// the dictionary memory sets this sequence.
// After reset, after each end of stream and after the dictionary fills, a
// clearing pass writes every hash slot while req.ready is low.
// A code emit waits while a finished word is still held in the output register.
module lzw_compressor_packed_unit import lzwc_pkg::*; #(
   parameter int START_WIDTH  = START_WIDTH_DEF,
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
   parameter int HASH_SLOTS   = HASH_SLOTS_DEF
) (
   input logic        clock,
   input logic        reset,
   lzwc_req_if.sink   req,
   lzwc_rsp_if.source rsp
);

   // Code values need to hold next_code up to DICT_ENTRIES itself.
   localparam int NC_W   = $clog2(DICT_ENTRIES + 1);
   localparam int HB     = $clog2(HASH_SLOTS);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = ((NC_W > MAX_WIDTH) ? NC_W : MAX_WIDTH) + 1;
   localparam int SLOT_W = 1 + NC_W + 8 + NC_W;
   localparam int KEY_W  = NC_W + 8;

   lzwc_state_type state_ff, state_in;

   logic [NC_W-1:0]  cur_ff, cur_in;
   logic             have_ff, have_in;
   logic [NC_W-1:0]  next_ff, next_in;
   logic [WID_W-1:0] width_ff, width_in;
   logic             action_ff, action_in;
   logic [7:0]       byte_ff, byte_in;
   logic [HB-1:0]    addr_ff, addr_in;
   logic [HB-1:0]    step_ff, step_in;
   logic             slot_ok_ff, slot_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_word_ff, rsp_word_in;
   logic [2:0]       rsp_count_ff, rsp_count_in;
   logic             rsp_end_ff, rsp_end_in;

   // Hash of the (prefix, byte) key: only the low HB product bits matter.
   logic [KEY_W-1:0]  key_full;
   logic [2*HB-1:0]   hash_prod;
   logic [HB-1:0]     hash_val;

   // Dictionary memory access.
   logic              mem_wr_en;
   logic [HB-1:0]     mem_wr_addr;
   logic [SLOT_W-1:0] mem_wr_data;
   logic [SLOT_W-1:0] mem_rd_data;
   logic              rd_valid;
   logic [NC_W-1:0]   rd_prefix;
   logic [7:0]        rd_byte;
   logic [NC_W-1:0]   rd_code;

   lzwc_pack_cmd_type pk_cmd;
   lzwc_pack_out_type pk_res;

   logic              accept;
   logic              out_free;
   logic              hit;
   logic              dict_full;
   logic [CMP_W-1:0]  width_mask;
   logic [CMP_W-1:0]  cur_masked;
   logic [CMP_W-1:0]  next_plus;
   logic              grow;

   lzwc_dict_mem #(
      .DEPTH  (HASH_SLOTS),
      .ADDR_W (HB),
      .DATA_W (SLOT_W)
   ) u_dict (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   lzwc_packer u_packer (
      .clock (clock),
      .reset (reset),
      .cmd   (pk_cmd),
      .res   (pk_res)
   );

   assign {rd_valid, rd_prefix, rd_byte, rd_code} = mem_rd_data;

   always_comb begin
      key_full  = {cur_ff, 8'd0} ^ {{NC_W{1'b0}}, req.data_byte};
      hash_prod = {{HB{1'b0}}, key_full[HB-1:0]} * {{HB{1'b0}}, HASH_MULT[HB-1:0]};
      hash_val  = hash_prod[HB-1:0];
   end

   assign accept     = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign hit        = rd_valid && (rd_prefix == cur_ff) && (rd_byte == byte_ff);
   assign dict_full  = (next_ff >= NC_W'(DICT_ENTRIES));
   assign width_mask = (CMP_W'(1) << width_ff) - CMP_W'(1);
   assign cur_masked = {{(CMP_W - NC_W){1'b0}}, cur_ff} & width_mask;
   assign next_plus  = {{(CMP_W - NC_W){1'b0}}, next_ff} + CMP_W'(1);
   assign grow       = (next_plus > (CMP_W'(1) << width_ff)) &&
                       (width_ff < WID_W'(MAX_WIDTH));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == {HB{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.action) begin
                  state_in = have_ff ? ST_EMIT_CUR : ST_EMIT_STOP;
               end else if (have_ff) begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit) begin
               state_in = ST_IDLE;
            end else if (!rd_valid || (step_ff == {HB{1'b1}})) begin
               state_in = ST_EMIT_CUR;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_EMIT_CUR: begin
            if (out_free) begin
               if (action_ff) begin
                  state_in = ST_EMIT_STOP;
               end else if (dict_full) begin
                  state_in = ST_EMIT_CLR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_CLR: begin
            if (out_free) begin
               state_in = ST_CLEAR;
            end
         end
         ST_EMIT_STOP: begin
            if (out_free) begin
               state_in = (pk_res.word_done && pk_res.empty_after) ? ST_CLEAR : ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control outputs: handshake, memory write and packer command.
   always_comb begin
      req.ready    = (state_ff == ST_IDLE);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = '0;
      pk_cmd.emit  = 1'b0;
      pk_cmd.flush = 1'b0;
      pk_cmd.value = PACK_VAL_W'(cur_masked);
      pk_cmd.nbits = PACK_LEN_W'(width_ff);
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_EMIT_CUR: begin
            pk_cmd.emit = out_free;
            // The new string is stored while its prefix code goes out.
            if (out_free && !action_ff && !dict_full && slot_ok_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {1'b1, cur_ff, byte_ff, next_ff};
            end
         end
         ST_EMIT_CLR: begin
            pk_cmd.emit  = out_free;
            pk_cmd.value = PACK_VAL_W'(CODE_CLEAR);
         end
         ST_EMIT_STOP: begin
            pk_cmd.emit  = out_free;
            pk_cmd.value = PACK_VAL_W'(CODE_STOP);
         end
         ST_FLUSH: begin
            pk_cmd.flush = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      cur_in       = cur_ff;
      have_in      = have_ff;
      next_in      = next_ff;
      width_in     = width_ff;
      action_in    = action_ff;
      byte_in      = byte_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      slot_ok_in   = slot_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      rsp_end_in   = rsp_end_ff;

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pk_res.word_done) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = pk_res.word;
         rsp_count_in = pk_res.count;
         rsp_end_in   = (state_ff == ST_FLUSH) ||
                        ((state_ff == ST_EMIT_STOP) && pk_res.empty_after);
      end

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + HB'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               action_in = req.action;
               byte_in   = req.data_byte;
               addr_in   = hash_val;
               step_in   = '0;
               if (!req.action && !have_ff) begin
                  cur_in  = NC_W'(req.data_byte);
                  have_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (hit) begin
               cur_in = rd_code;
            end else if (!rd_valid) begin
               slot_ok_in = 1'b1;
            end else if (step_ff == {HB{1'b1}}) begin
               slot_ok_in = 1'b0;
            end else begin
               addr_in = addr_ff + HB'(1);
               step_in = step_ff + HB'(1);
            end
         end
         ST_EMIT_CUR: begin
            if (out_free && !action_ff && !dict_full) begin
               next_in = next_ff + NC_W'(1);
               cur_in  = NC_W'(byte_ff);
               if (grow) begin
                  width_in = width_ff + WID_W'(1);
               end
            end
         end
         ST_EMIT_CLR: begin
            if (out_free) begin
               cur_in   = NC_W'(byte_ff);
               next_in  = NC_W'(CODE_FIRST);
               width_in = WID_W'(START_WIDTH);
               addr_in  = '0;
            end
         end
         ST_EMIT_STOP, ST_FLUSH: begin
            // The stream is over; prefix, code counter, width and address return to their reset values.
            if (out_free && (state_in == ST_CLEAR)) begin
               cur_in   = '0;
               have_in  = 1'b0;
               next_in  = NC_W'(CODE_FIRST);
               width_in = WID_W'(START_WIDTH);
               addr_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         have_ff      <= 1'b0;
         next_ff      <= NC_W'(CODE_FIRST);
         width_ff     <= WID_W'(START_WIDTH);
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         have_ff      <= have_in;
         next_ff      <= next_in;
         width_ff     <= width_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      byte_ff      <= byte_in;
      step_ff      <= step_in;
      slot_ok_ff   <= slot_ok_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.packed_word = rsp_word_ff;
   assign rsp.byte_count  = rsp_count_ff;
   assign rsp.stream_end  = rsp_end_ff;

endmodule

// ===== design/lzwc_checker.sv =====
// Port-level assertions for the LZW compressor and their binding to the top level.
module lzwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic [2:0]  rsp_count,
   input logic        rsp_end
);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count >= 3'd1) && (rsp_count <= 3'd4))
      else $error("byte count out of range");

   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_count != 3'd4) |-> rsp_end)
      else $error("partial word that does not end the stream");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_count))
      else $error("stalled word changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

   a_end_then_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end |=> !rsp_valid && !req_ready)
      else $error("activity right after the end of a stream");

endmodule

bind lzw_compressor_packed_unit lzwc_checker u_lzwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_word  (rsp.packed_word),
   .rsp_count (rsp.byte_count),
   .rsp_end   (rsp.stream_end)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the LZW compressor with variable code width and word packing.
module tb_top;
   import lzwc_pkg::*;

   localparam int SLOTS       = HASH_SLOTS_DEF;
   localparam int ENTRIES     = DICT_ENTRIES_DEF;
   localparam int FIRST_WIDTH = START_WIDTH_DEF;
   localparam int LAST_WIDTH  = MAX_WIDTH_DEF;

   // The two kinds of input word.
   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_EOS  = 1'b1;

   // One expected packed output word.
   typedef struct {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } packed_word_type;

   logic clock;
   logic reset;

   lzwc_req_if req ();
   lzwc_rsp_if rsp ();

   lzw_compressor_packed_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Shadow copy of the compressor state, kept up to date on every accepted word.
   logic        dict_valid [SLOTS];
   logic [11:0] dict_prefix [SLOTS];
   logic [7:0]  dict_byte [SLOTS];
   logic [12:0] dict_code [SLOTS];
   logic [11:0] cur_code;
   logic        have_cur;
   int unsigned next_free;
   int unsigned width;
   logic [31:0] pack_buf;
   int unsigned pack_bits;

   packed_word_type words_due [$];
   packed_word_type step_words [$];

   int mismatches;
   int words_checked;
   int streams_sent;
   int items_sent;
   int burst_left;
   int hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clears the dictionary and restarts the code width, as a clear code does.
   function automatic void dict_restart();
      for (int i = 0; i < SLOTS; i++) dict_valid[i] = 1'b0;
      next_free = CODE_FIRST;
      width     = FIRST_WIDTH;
   endfunction

   function automatic void lzw_restart();
      dict_restart();
      cur_code  = '0;
      have_cur  = 1'b0;
      pack_buf  = '0;
      pack_bits = 0;
   endfunction

   // Packs a code MSB-first; a code that straddles a word puts its low bits first.
   function automatic void pack_code(input logic [31:0] value, input int unsigned nbits);
      int unsigned room;
      int unsigned take;
      packed_word_type w;
      while (nbits > 0) begin
         room = 32 - pack_bits;
         take = (nbits < room) ? nbits : room;
         pack_buf  = pack_buf | ((value & ((32'd1 << take) - 1)) << (32 - pack_bits - take));
         pack_bits = pack_bits + take;
         nbits     = nbits - take;
         value     = value >> take;
         if (pack_bits == 32) begin
            w.word  = pack_buf;
            w.count = 3'd4;
            w.last  = 1'b0;
            step_words = {step_words, w};
            pack_buf  = '0;
            pack_bits = 0;
         end
      end
   endfunction

   // Works out the packed words that one accepted input word causes.
   function automatic void lzw_predict(input logic act, input logic [7:0] b);
      logic [31:0] mask;
      logic [31:0] h;
      int unsigned idx;
      bit          found;
      bit          have_slot;
      packed_word_type w;
      mask = (32'd1 << width) - 1;
      step_words.delete();
      if (act == ACT_DATA) begin
         if (!have_cur) begin
            cur_code = {4'd0, b};
            have_cur = 1'b1;
            return;
         end
         h = (({20'd0, cur_code} << 8) ^ {24'd0, b}) * HASH_MULT;
         idx = h % SLOTS;
         found = 0;
         have_slot = 0;
         // Linear probing until a match or a free slot turns up.
         for (int i = 0; i < SLOTS; i++) begin
            if (!dict_valid[idx]) begin
               have_slot = 1;
               break;
            end
            if (dict_prefix[idx] == cur_code && dict_byte[idx] == b) begin
               found = 1;
               break;
            end
            idx = (idx + 1) % SLOTS;
         end
         if (found) begin
            cur_code = dict_code[idx][11:0];
            return;
         end
         pack_code({20'd0, cur_code} & mask, width);
         if (next_free < ENTRIES) begin
            if (have_slot) begin
               dict_valid[idx]  = 1'b1;
               dict_prefix[idx] = cur_code;
               dict_byte[idx]   = b;
               dict_code[idx]   = next_free[12:0];
            end
            next_free++;
            if (next_free > (1 << width) && width < LAST_WIDTH) width++;
         end else begin
            pack_code(CODE_CLEAR & mask, width);
            dict_restart();
         end
         cur_code = {4'd0, b};
      end else begin
         if (have_cur) pack_code({20'd0, cur_code} & mask, width);
         pack_code(CODE_STOP & mask, width);
         if (pack_bits > 0) begin
            w.word  = pack_buf;
            w.count = 3'((pack_bits + 7) / 8);
            w.last  = 1'b0;
            step_words = {step_words, w};
         end
         if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
         lzw_restart();
         streams_sent++;
      end
      foreach (step_words[i]) words_due = {words_due, step_words[i]};
   endfunction

   // Offers one input word and holds it until the block takes it. Between bursts the
   // valid line may drop for a random gap; inside a burst it stays high.
   task automatic send_word(input logic act, input logic [7:0] b);
      int gap;
      req.valid     <= 1'b1;
      req.action    <= act;
      req.data_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      lzw_predict(act, b);
      items_sent++;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Stops offering, waits until every predicted word has come out, then lets the
   // block settle.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (words_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic send_stream(input int len, input int alphabet);
      for (int i = 0; i < len; i++) send_word(ACT_DATA, 8'($urandom_range(0, alphabet)));
      send_word(ACT_EOS, 8'($urandom_range(0, 255)));
   endtask

   // Empty stream, single bytes at both extremes, and a data field on end of
   // stream that must be ignored.
   task automatic test_short_streams();
      send_word(ACT_EOS, 8'hA5);
      send_word(ACT_DATA, 8'h00);
      send_word(ACT_EOS, 8'hFF);
      send_word(ACT_DATA, 8'hFF);
      send_word(ACT_EOS, 8'h00);
      wait_drained();
   endtask

   // Runs of one byte build ever longer strings, so lookups hit the dictionary.
   task automatic test_repeats();
      for (int i = 0; i < 12; i++) send_word(ACT_DATA, 8'h55);
      send_word(ACT_DATA, 8'hAA);
      send_word(ACT_DATA, 8'h55);
      send_word(ACT_DATA, 8'hAA);
      send_word(ACT_EOS, 8'h00);
      wait_drained();
   endtask

   // A long stream of varied bytes pushes the code width from 9 up to 11 bits.
   task automatic test_width_growth();
      send_stream(850, 255);
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering.
   // The hold starts only once the block takes input again.
   task automatic test_backpressure();
      while (!req.ready) @(posedge clock);
      hold_request = 400;
      send_stream(60, 255);
      wait_drained();
   endtask

   // Mostly short streams over small alphabets, so strings recur, with a few
   // longer ones and some over the full byte range.
   task automatic test_random_streams();
      int len;
      int alphabet;
      while (items_sent < 1100) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 50);
         case ($urandom_range(0, 3))
            0: alphabet = 1;
            1: alphabet = 3;
            2: alphabet = 15;
            default: alphabet = 255;
         endcase
         send_stream(len, alphabet);
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // Receiver: stalls on its own pattern, alternating between stretches of random
   // stalls and stretches where it is always ready. A requested hold-off is
   // counted down here, cycle by cycle.
   initial begin : receiver
      int phase_left;
      bit stall_mode;
      phase_left = 0;
      stall_mode = 0;
      hold_request = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 200);
            stall_mode = ~stall_mode;
         end
         phase_left--;
         if (hold_request > 0) begin
            rsp.ready <= 1'b0;
            hold_request--;
         end else if (stall_mode) begin
            rsp.ready <= ($urandom_range(0, 2) != 0);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Checker: every accepted output word is compared with the oldest prediction.
   always @(posedge clock) begin
      packed_word_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word %h count %0d end %0b",
                        rsp.packed_word, rsp.byte_count, rsp.stream_end);
         end else begin
            w = words_due.pop_front();
            words_checked++;
            if (rsp.packed_word !== w.word || rsp.byte_count !== w.count
                || rsp.stream_end !== w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                           w.word, w.count, w.last,
                           rsp.packed_word, rsp.byte_count, rsp.stream_end);
            end
         end
      end
   end

   // Main sequence: reset once, then each test in turn.
   initial begin
      mismatches    = 0;
      words_checked = 0;
      streams_sent  = 0;
      items_sent    = 0;
      burst_left    = 0;
      lzw_restart();
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.action    <= ACT_DATA;
      req.data_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_short_streams();
      test_repeats();
      test_width_growth();
      test_backpressure();
      test_random_streams();

      wait_drained();
      repeat (100) @(posedge clock);
      if (words_due.size() != 0) mismatches++;

      $display("Sent %0d input words in %0d streams and checked %0d packed words,",
               items_sent, streams_sent, words_checked);
      $display("covering width growth, end-of-stream flushes and output back-pressure.");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #60000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/lzwc_pkg.sv
design/lzwc_if.sv
design/lzwc_dict_mem.sv
design/lzwc_packer.sv
design/lzw_compressor_packed_unit.sv
design/lzwc_checker.sv
tb/tb_top.sv
